// ----- rtl/sha256_pkg.sv -----
// sha256_pkg: constants and round functions for the sha-256 hasher
// used by sha256_message_hasher_unit; no dependencies
package sha256_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds = 64;
    localparam int unsigned DigestWords = 8;

    localparam logic [7:0] PadByte = 8'h80;

    localparam logic [31:0] InitHash [DigestWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ----- rtl/sha256_message_hasher_unit.sv -----
// sha256_message_hasher_unit: byte-serial sha-256 hasher with iterative round unit
// depends on sha256_pkg
//
// Takes one message byte per input item, gathers 64-byte blocks in a 16-word
// schedule window and folds each full block into the chaining hash with a
// single round unit that runs one sha-256 round per cycle. A byte item is taken
// while idle; the 64th byte of a block holds in_stall high through all 64
// rounds and the add into the chaining hash. The item with end_of_message (with
// or without a byte) first finishes any block that its byte fills, then pads
// the remaining word slots of the closing block (at most 16), the first of them
// placing the 0x80 pad byte, then runs a compression. When 56 or more bytes sit
// in the last block, a second pass of 16 pad words and another compression
// carry the length. The eight digest words then leave one per cycle while
// out_stall is low, most significant first, word_index 0..7, with last_word on
// word 7. The block stays stalled until the last digest word is taken, then
// returns to the initial hash values and a zero byte count. No byte is taken
// while a block is compressed. No clearing pass after reset is needed.
module sha256_message_hasher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    state_t       state_reg;
    logic [31:0]  h_reg [8];
    logic [31:0]  s_reg [8];
    // schedule window: w_reg[0] is the word used this round
    logic [31:0]  w_reg [16];
    logic [63:0]  count_reg;
    logic [5:0]   round_reg;
    logic [3:0]   pad_idx_reg;
    logic         final_reg;   // message end in progress
    logic         extra_reg;   // another (length) block follows
    logic         lead_reg;    // 0x80 pad byte not placed yet
    logic [2:0]   emit_reg;

    logic         accept;
    logic [5:0]   byte_pos;
    logic [31:0]  t1, t2, w_new;
    logic [31:0]  pad_word;
    logic [63:0]  bit_len;
    logic [3:0]   fill_word;   // word slot of the next byte
    logic [31:0]  cur_word;
    logic [31:0]  byte_word;
    logic [63:0]  count_inc;
    logic [63:0]  end_count;

    assign in_stall    = (state_reg != ST_IDLE);
    assign accept      = in_valid && !in_stall;
    assign byte_pos    = count_reg[5:0];
    assign fill_word   = byte_pos[5:2];
    assign bit_len     = {count_reg[60:0], 3'b000};
    assign out_valid   = (state_reg == ST_EMIT);
    assign digest_word = h_reg[emit_reg];
    assign word_index  = emit_reg;
    assign last_word   = (emit_reg == 3'd7);

    // current partial word (bytes already in w_reg[15] low bits)
    assign cur_word  = w_reg[15];
    assign byte_word = {cur_word[23:0], data_byte};
    assign count_inc = count_reg + 64'd1;
    assign end_count = has_byte ? count_inc : count_reg;

    assign t1 = s_reg[7] + sha256_pkg::bsig1(s_reg[4])
              + ((s_reg[4] & s_reg[5]) ^ (~s_reg[4] & s_reg[6]))
              + sha256_pkg::RoundK[round_reg] + w_reg[0];
    assign t2 = sha256_pkg::bsig0(s_reg[0])
              + ((s_reg[0] & s_reg[1]) ^ (s_reg[0] & s_reg[2]) ^ (s_reg[1] & s_reg[2]));
    assign w_new = sha256_pkg::sig1(w_reg[14]) + w_reg[9]
                 + sha256_pkg::sig0(w_reg[1]) + w_reg[0];

    // pad word for the word slot pad_idx_reg of the closing block
    always_comb
    begin
        pad_word = 32'h0;
        if (lead_reg)
        begin
            // pad byte goes right after the last message byte
            case (count_reg[1:0])
                2'd0: pad_word = {sha256_pkg::PadByte, 24'h0};
                2'd1: pad_word = {cur_word[7:0], sha256_pkg::PadByte, 16'h0};
                2'd2: pad_word = {cur_word[15:0], sha256_pkg::PadByte, 8'h0};
                default: pad_word = {cur_word[23:0], sha256_pkg::PadByte};
            endcase
        end
        else if (!extra_reg && pad_idx_reg == 4'd14)
        begin
            pad_word = bit_len[63:32];
        end
        else if (!extra_reg && pad_idx_reg == 4'd15)
        begin
            pad_word = bit_len[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            round_reg   <= '0;
            pad_idx_reg <= '0;
            final_reg   <= 1'b0;
            extra_reg   <= 1'b0;
            lead_reg    <= 1'b0;
            emit_reg    <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256_pkg::InitHash[i];
                s_reg[i] <= '0;
            end
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (has_byte)
                        begin
                            count_reg <= count_inc;
                            // a new word enters the window on its first byte
                            if (count_reg[1:0] == 2'd0)
                            begin
                                for (int i = 0; i < 15; i++)
                                begin
                                    w_reg[i] <= w_reg[i + 1];
                                end
                            end
                            w_reg[15] <= byte_word;
                        end
                        if (end_of_message)
                        begin
                            final_reg   <= 1'b1;
                            lead_reg    <= 1'b1;
                            extra_reg   <= (end_count[5:0] >= 6'd56);
                            pad_idx_reg <= end_count[5:2];
                        end
                        if (has_byte && count_inc[5:0] == 6'd0)
                        begin
                            round_reg <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                s_reg[i] <= h_reg[i];
                            end
                            state_reg <= ST_ROUND;
                        end
                        else if (end_of_message)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    // a partial word is already in the window and is completed in place
                    if (!(lead_reg && count_reg[1:0] != 2'd0))
                    begin
                        for (int i = 0; i < 15; i++)
                        begin
                            w_reg[i] <= w_reg[i + 1];
                        end
                    end
                    w_reg[15]   <= pad_word;
                    lead_reg    <= 1'b0;
                    pad_idx_reg <= pad_idx_reg + 4'd1;
                    if (pad_idx_reg == 4'd15)
                    begin
                        round_reg <= '0;
                        for (int i = 0; i < 8; i++)
                        begin
                            s_reg[i] <= h_reg[i];
                        end
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    s_reg[7] <= s_reg[6];
                    s_reg[6] <= s_reg[5];
                    s_reg[5] <= s_reg[4];
                    s_reg[4] <= s_reg[3] + t1;
                    s_reg[3] <= s_reg[2];
                    s_reg[2] <= s_reg[1];
                    s_reg[1] <= s_reg[0];
                    s_reg[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= w_reg[i + 1];
                    end
                    w_reg[15] <= w_new;
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                    begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + s_reg[i];
                    end
                    if (!final_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (lead_reg)
                    begin
                        // last byte filled the block, padding starts a fresh one
                        pad_idx_reg <= '0;
                        state_reg   <= ST_PAD;
                    end
                    else if (extra_reg)
                    begin
                        // length-only block follows
                        extra_reg   <= 1'b0;
                        pad_idx_reg <= '0;
                        state_reg   <= ST_PAD;
                    end
                    else
                    begin
                        emit_reg  <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (!out_stall)
                    begin
                        emit_reg <= emit_reg + 3'd1;
                        if (emit_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= sha256_pkg::InitHash[i];
                            end
                            count_reg <= '0;
                            final_reg <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // an end item without a byte, with 56 or more bytes in the block, must schedule the length block
    property p_long_tail;
        @(posedge clk) disable iff (!rst_n)
        (accept && end_of_message && !has_byte && fill_word >= 4'd14) |=> extra_reg;
    endproperty
    a_long_tail: assert property (p_long_tail) else $error("long tail block not scheduled");

    a_no_emit_midblock: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> final_reg && !extra_reg)
        else $error("digest shown before final block");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_word) |=> (state_reg == ST_IDLE && count_reg == 64'd0))
        else $error("hasher did not reset after digest");

    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD) |-> $past(round_reg) == 6'd63)
        else $error("fold without full round sequence");

endmodule
